/* sv/smbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smbs_pkg;

   localparam int SAMPLE_W        = 32;   // Q25.7 bin intensity
   localparam int VALUE_W         = 33;   // signed Q.7 result
   localparam int FRAC_W          = 24;   // reciprocal fraction bits
   localparam int WINDOW_HALF_DEF = 75;

   // one stored bin: window contribution and its pad flag
   typedef struct packed {
      logic                pad;
      logic [SAMPLE_W-1:0] val;
   } entry_type;

   // bin whose result is due, handed to the scaling pipeline
   typedef struct packed {
      logic [SAMPLE_W-1:0] xc;
      logic                last;
   } due_type;

endpackage

`default_nettype wire

/* sv/smbs_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface smbs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;
   logic        is_pad;

   modport source (output valid, output sample, output is_pad, input ready);
   modport sink   (input valid, input sample, input is_pad, output ready);
endinterface

interface smbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [32:0] value;
   logic               last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* sv/smbs_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module smbs_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 shift_en,
   input  wire                 clear,
   input  smbs_pkg::entry_type d,
   output smbs_pkg::entry_type q
);
   import smbs_pkg::*;

   logic      valid_ff;
   entry_type data_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= d;
      end
   end

   // an empty cell reads as a zero bin
   assign q = valid_ff ? data_ff : '0;

endmodule

`default_nettype wire

/* sv/smbs_line.sv */
`timescale 1ns / 1ps
`default_nettype none

module smbs_line #(
   parameter int WINDOW_HALF = smbs_pkg::WINDOW_HALF_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 shift_en,
   input  wire                 clear,
   input  smbs_pkg::entry_type entry_in,
   output smbs_pkg::entry_type due,
   output smbs_pkg::entry_type next,
   output smbs_pkg::entry_type tail
);
   import smbs_pkg::*;

   localparam int DEPTH = 2 * WINDOW_HALF + 1;

   // tap k is the input of cell k, i.e. what cell k holds after the next shift
   entry_type taps [DEPTH+1];

   assign taps[0] = entry_in;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      smbs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .clear    (clear),
         .d        (taps[k]),
         .q        (taps[k+1])
      );
   end

   assign due  = taps[WINDOW_HALF];
   assign next = taps[WINDOW_HALF-1];
   assign tail = taps[DEPTH];

endmodule

`default_nettype wire

/* sv/smbs_scale.sv */
`timescale 1ns / 1ps
`default_nettype none

module smbs_scale #(
   parameter int                          SUM_W = 40,
   parameter logic [smbs_pkg::FRAC_W-1:0] RECIP = '0
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire [SUM_W-1:0]      in_sum,
   input  smbs_pkg::due_type    in_due,
   smbs_rsp_if.source           rsp
);
   import smbs_pkg::*;

   localparam int TW   = SUM_W + 1;
   localparam int TH_W = TW - FRAC_W;
   localparam int PH_W = TH_W + FRAC_W + 1;
   localparam int PL_W = 2 * FRAC_W;
   localparam int RQ_W = PL_W - FRAC_W + 1;
   localparam int M_W  = PH_W + 1;
   localparam int V_W  = M_W + 1;

   localparam logic signed [V_W-1:0] SAT_HI = {{(V_W-SAMPLE_W){1'b0}}, {SAMPLE_W{1'b1}}};
   localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI;
   localparam logic [PL_W:0]         HALF   = (PL_W+1)'(1) << (FRAC_W - 1);

   logic v2_ff, v3_ff, v4_ff, v5_ff;
   logic r2, r3, r4, r5;

   // stage 2: window sum less the due bin
   logic signed [TW-1:0]   t2_ff, t2_in;
   due_type                d2_ff;
   // stage 3: two partial products
   logic [PL_W-1:0]        pl3_ff, pl3_in;
   logic signed [PH_W-1:0] ph3_ff, ph3_in;
   due_type                d3_ff;
   // stage 4: rounded mean
   logic [PL_W:0]          rsum;
   logic [RQ_W-1:0]        rq;
   logic signed [M_W-1:0]  m4_ff, m4_in;
   due_type                d4_ff;
   // stage 5: output register
   logic signed [V_W-1:0]  v5;
   logic [VALUE_W-1:0]     val5_in;

   assign r5       = !v5_ff || rsp.ready;
   assign r4       = !v4_ff || r5;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign in_ready = r2;

   always_comb begin
      t2_in  = $signed({1'b0, in_sum}) - $signed({{(TW-SAMPLE_W){1'b0}}, in_due.xc});
      pl3_in = t2_ff[FRAC_W-1:0] * RECIP;
      ph3_in = $signed(t2_ff[TW-1:FRAC_W]) * $signed({1'b0, RECIP});
      rsum   = {1'b0, pl3_ff} + HALF;
      rq     = rsum[PL_W:FRAC_W];
      m4_in  = $signed({ph3_ff[PH_W-1], ph3_ff}) + $signed({{(M_W-RQ_W){1'b0}}, rq});
      v5     = $signed({{(V_W-SAMPLE_W){1'b0}}, d4_ff.xc}) - $signed({m4_ff[M_W-1], m4_ff});
      priority if (v5 > SAT_HI) begin
         val5_in = SAT_HI[VALUE_W-1:0];
      end else if (v5 < SAT_LO) begin
         val5_in = SAT_LO[VALUE_W-1:0];
      end else begin
         val5_in = v5[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (r2) v2_ff <= in_valid;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r2 && in_valid) begin
         t2_ff <= t2_in;
         d2_ff <= in_due;
      end
      if (r3 && v2_ff) begin
         pl3_ff <= pl3_in;
         ph3_ff <= ph3_in;
         d3_ff  <= d2_ff;
      end
      if (r4 && v3_ff) begin
         m4_ff <= m4_in;
         d4_ff <= d3_ff;
      end
      if (r5 && v4_ff) begin
         rsp.value <= $signed(val5_in);
         rsp.last  <= d4_ff.last;
      end
   end

   assign rsp.valid = v5_ff;

endmodule

`default_nettype wire

/* sv/sliding_mean_background_subtract_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sliding-mean background subtraction over a stream of spectrum bins. Each req transfer carries
// one Q25.7 bin (or a pad bin, which counts as zero); each rsp transfer gives a bin's value less
// the rounded mean of its neighbours within WINDOW_HALF bins either side (itself excluded, divisor
// fixed at 2*WINDOW_HALF, bin 0 never counted in a window and subtracted once more from its own).
// A bin's result becomes due when the bin WINDOW_HALF places later is taken, so a spectrum must
// be followed by WINDOW_HALF pad transfers; the final real bin's result carries last, after which
// the block is back in its reset state and drops any bins taken after the first pad. One bin is
// taken every cycle unless rsp back-pressure fills the pipeline; a result passes from the transfer
// that makes it due through one window-update stage and four stages of scaling (subtract, split
// multiply, rounding, saturation). The window is a row of 2*WINDOW_HALF+1 shift cells.
module sliding_mean_background_subtract_core #(
   parameter int WINDOW_HALF = smbs_pkg::WINDOW_HALF_DEF
) (
   input  wire        clock,
   input  wire        reset,
   smbs_req_if.sink   req,
   smbs_rsp_if.source rsp
);
   import smbs_pkg::*;

   localparam int DEPTH = 2 * WINDOW_HALF + 1;
   localparam int SUM_W = SAMPLE_W + $clog2(DEPTH + 1);
   localparam int POS_W = $clog2(WINDOW_HALF + 2);
   localparam logic [POS_W-1:0] POS_DUE = POS_W'(WINDOW_HALF);
   localparam logic [POS_W-1:0] POS_SAT = POS_W'(WINDOW_HALF + 1);
   // 2^24 / (2*WINDOW_HALF), rounded half up
   localparam logic [FRAC_W-1:0] RECIP =
      FRAC_W'(((64'd1 << FRAC_W) + 64'(WINDOW_HALF)) / 64'(2 * WINDOW_HALF));

   // front end state
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [SAMPLE_W-1:0] first_ff, first_in;

   // stage 1 register, feeding the scaling pipeline
   logic                s1_valid_ff;
   logic [SUM_W-1:0]    s1_sum_ff;
   due_type             s1_due_ff;

   logic                scale_ready;
   logic                fire;
   logic                emit;
   logic                flush;
   logic [SAMPLE_W-1:0] contrib;
   entry_type           entry_in;
   entry_type           due;
   entry_type           next;
   entry_type           tail;
   due_type             due_in;

   assign req.ready = !s1_valid_ff || scale_ready;
   assign fire      = req.valid && req.ready;

   smbs_line #(
      .WINDOW_HALF (WINDOW_HALF)
   ) u_line (
      .clock    (clock),
      .reset    (reset),
      .shift_en (fire),
      .clear    (flush),
      .entry_in (entry_in),
      .due      (due),
      .next     (next),
      .tail     (tail)
   );

   always_comb begin
      // bin 0 and pad bins add nothing to any window
      contrib      = (req.is_pad || pos_ff == '0) ? '0 : req.sample;
      entry_in.pad = req.is_pad;
      entry_in.val = contrib;

      // oldest bin leaves the window, newest one enters
      sum_in = sum_ff - {{(SUM_W-SAMPLE_W){1'b0}}, tail.val}
                      + {{(SUM_W-SAMPLE_W){1'b0}}, contrib};

      // the due bin has WINDOW_HALF bins taken after it and is real
      emit = (pos_ff >= POS_DUE) && !due.pad;
      // the due bin is bin 0 exactly when the first result becomes due
      due_in.xc   = (pos_ff == POS_DUE) ? first_ff : due.val;
      due_in.last = next.pad;

      flush = fire && emit && next.pad;

      pos_in   = (pos_ff == POS_SAT) ? pos_ff : pos_ff + POS_W'(1);
      first_in = (pos_ff == '0) ? (req.is_pad ? '0 : req.sample) : first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         sum_ff   <= '0;
         pos_ff   <= '0;
         first_ff <= '0;
      end else if (fire) begin
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         first_ff <= first_in;
      end
   end

   // stage 1: hold the updated window sum and the due bin
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && req.ready) begin
         s1_sum_ff <= sum_in;
         s1_due_ff <= due_in;
      end
   end

   smbs_scale #(
      .SUM_W (SUM_W),
      .RECIP (RECIP)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ready (scale_ready),
      .in_sum   (s1_sum_ff),
      .in_due   (s1_due_ff),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire
